@@ src/serial_line_csr_interface_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Serial line CSR unit assertion macros
// Shared concurrent assertion forms for the serial line unit checkers.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_CSR_INTERFACE_UNIT_DEFINES_SVH
`define SERIAL_LINE_CSR_INTERFACE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SLCI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SLCI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define SLCI_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/slci_pkg.sv @@
// ----------------------------------------------------------------------------
// Serial line CSR unit package
// Request codes, register selects, bit positions and item types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slci_pkg;

  // Kind of request carried by one input item.
  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_OFFER = 2'd3
  } req_kind_t;

  // Register select, taken from offset bits 2:1.
  typedef enum logic [1:0] {
    SEL_RX_STATUS = 2'd0,
    SEL_RX_BUFFER = 2'd1,
    SEL_TX_STATUS = 2'd2,
    SEL_TX_BUFFER = 2'd3
  } sel_t;

  // Status register bit positions.
  localparam int FLAG_BIT = 7;
  localparam int IE_BIT   = 6;

  // Interrupt vector codes.
  localparam logic VEC_RX = 1'b0;
  localparam logic VEC_TX = 1'b1;

  localparam logic [15:0] CHAR_TICKS_RESET = 16'd1042;

  // One request as held in the input register.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  reg_offset;
    logic [15:0] write_data;
    logic [7:0]  rx_char;
  } req_t;

  // One result as held in the result register.
  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [6:0] tx_char;
    logic       irq_valid;
    logic       irq_vector;
    logic       rx_accepted;
  } rsp_t;

endpackage

@@ src/serial_line_csr_interface_unit.sv @@
// ----------------------------------------------------------------------------
// Serial line CSR interface unit
// Four-register serial line unit: receiver and transmitter status and buffer.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  input     in_valid / in_stall   req_type, reg_offset, write_data, rx_char
//  output    out_valid / out_stall read_data, tx_valid, tx_char, irq_valid,
//                                  irq_vector, rx_accepted
//  config    cfg_we                cfg_wdata (character time in ticks)
//
//  One request per cycle sustained while the result side does not stall; a
//  result passes the input register, then the result register. The register
//  update is a single pass of flag and counter logic. Synchronous reset
//  clears the receive flag and both interrupt enables, sets the transmitter
//  ready flag, empties both registers and restores the character time to
//  1042 ticks. A stall on the result side holds both registers; flag and
//  counter state changes only when a request moves into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_line_csr_interface_unit
  import slci_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [2:0]  reg_offset,
  input  logic [15:0] write_data,
  input  logic [7:0]  rx_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        tx_valid,
  output logic [6:0]  tx_char,
  output logic        irq_valid,
  output logic        irq_vector,
  output logic        rx_accepted,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  req_t in_req;
  req_t req;
  rsp_t rsp_next;
  rsp_t rsp;
  logic hold;
  logic fire;

  // Gather the request fields.
  assign in_req.req_type   = req_type;
  assign in_req.reg_offset = reg_offset;
  assign in_req.write_data = write_data;
  assign in_req.rx_char    = rx_char;

  slci_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .hold     (hold),
    .fire     (fire),
    .req      (req)
  );

  slci_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .req       (req),
    .rsp       (rsp_next)
  );

  slci_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .rsp_in    (rsp_next),
    .hold      (hold),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rsp       (rsp)
  );

  // Spread the result onto its ports.
  assign read_data   = rsp.read_data;
  assign tx_valid    = rsp.tx_valid;
  assign tx_char     = rsp.tx_char;
  assign irq_valid   = rsp.irq_valid;
  assign irq_vector  = rsp.irq_vector;
  assign rx_accepted = rsp.rx_accepted;

endmodule

@@ src/slci_in_stage.sv @@
// ----------------------------------------------------------------------------
// Serial line CSR unit input register
// Captures one request and holds it while the result side is blocked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slci_in_stage
  import slci_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_req,
  input  logic hold,
  output logic fire,
  output req_t req
);

  logic valid;

  // Blocked only when a request is held and cannot move on.
  assign in_stall = valid && hold;
  assign fire     = valid && !hold;

  // Valid flag follows the upstream side whenever the register is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  // Payload loads with the flag.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      req <= in_req;
    end
  end

endmodule

@@ src/slci_core.sv @@
// ----------------------------------------------------------------------------
// Serial line CSR unit register core
// Receiver and transmitter state, and the result of each request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slci_core
  import slci_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        fire,
  input  req_t        req,
  output rsp_t        rsp
);

  logic [15:0] char_ticks;
  logic        rx_done, rx_done_next;
  logic        rx_int_enable, rx_int_enable_next;
  logic [7:0]  rx_holding, rx_holding_next;
  logic        tx_ready, tx_ready_next;
  logic        tx_int_enable, tx_int_enable_next;
  logic [15:0] tx_countdown, tx_countdown_next;

  sel_t        sel;
  logic [15:0] reload;

  assign sel    = sel_t'(req.reg_offset[2:1]);
  // A zero character time behaves as one tick.
  assign reload = (char_ticks == 16'd0) ? 16'd1 : char_ticks;

  // Character time register.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_ticks <= CHAR_TICKS_RESET;
    end else if (cfg_we) begin
      char_ticks <= cfg_wdata;
    end
  end

  // Next state and result for the request in the input register.
  always_comb begin
    rx_done_next       = rx_done;
    rx_int_enable_next = rx_int_enable;
    rx_holding_next    = rx_holding;
    tx_ready_next      = tx_ready;
    tx_int_enable_next = tx_int_enable;
    tx_countdown_next  = tx_countdown;
    rsp                = '0;

    case (req_kind_t'(req.req_type))
      REQ_READ: begin
        case (sel)
          SEL_RX_STATUS: begin
            rsp.read_data[FLAG_BIT] = rx_done;
            rsp.read_data[IE_BIT]   = rx_int_enable;
          end
          SEL_RX_BUFFER: begin
            rsp.read_data = rx_holding;
            rx_done_next  = 1'b0;
          end
          SEL_TX_STATUS: begin
            rsp.read_data[FLAG_BIT] = tx_ready;
            rsp.read_data[IE_BIT]   = tx_int_enable;
          end
          default: ;
        endcase
      end
      REQ_WRITE: begin
        case (sel)
          SEL_RX_STATUS: begin
            rx_int_enable_next = req.write_data[IE_BIT];
            rsp.irq_valid      = req.write_data[IE_BIT] && rx_done;
            rsp.irq_vector     = VEC_RX;
          end
          SEL_TX_STATUS: begin
            tx_int_enable_next = req.write_data[IE_BIT];
            rsp.irq_valid      = req.write_data[IE_BIT] && tx_ready;
            rsp.irq_vector     = rsp.irq_valid ? VEC_TX : VEC_RX;
          end
          SEL_TX_BUFFER: begin
            rsp.tx_valid      = 1'b1;
            rsp.tx_char       = req.write_data[6:0];
            tx_ready_next     = 1'b0;
            tx_countdown_next = reload;
          end
          default: ;
        endcase
      end
      REQ_TICK: begin
        // The countdown runs only while a character is on the line.
        if (!tx_ready) begin
          if (tx_countdown[15:1] != 15'd0) begin
            tx_countdown_next = tx_countdown - 16'd1;
          end else begin
            tx_countdown_next = 16'd0;
            tx_ready_next     = 1'b1;
            rsp.irq_valid     = tx_int_enable;
            rsp.irq_vector    = tx_int_enable ? VEC_TX : VEC_RX;
          end
        end
      end
      REQ_OFFER: begin
        // A character is taken only when the holding register is empty.
        if (!rx_done) begin
          rx_holding_next = req.rx_char;
          rx_done_next    = 1'b1;
          rsp.rx_accepted = 1'b1;
          rsp.irq_valid   = rx_int_enable;
          rsp.irq_vector  = VEC_RX;
        end
      end
      default: ;
    endcase
  end

  // State commits when the request moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_done       <= 1'b0;
      rx_int_enable <= 1'b0;
      rx_holding    <= 8'd0;
      tx_ready      <= 1'b1;
      tx_int_enable <= 1'b0;
      tx_countdown  <= 16'd0;
    end else if (fire) begin
      rx_done       <= rx_done_next;
      rx_int_enable <= rx_int_enable_next;
      rx_holding    <= rx_holding_next;
      tx_ready      <= tx_ready_next;
      tx_int_enable <= tx_int_enable_next;
      tx_countdown  <= tx_countdown_next;
    end
  end

endmodule

@@ src/slci_out_stage.sv @@
// ----------------------------------------------------------------------------
// Serial line CSR unit result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slci_out_stage
  import slci_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  rsp_t rsp_in,
  output logic hold,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t rsp
);

  // The register is busy while a result waits behind a stall.
  assign hold = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      rsp <= rsp_in;
    end
  end

endmodule

@@ src/slci_checker.sv @@
// ----------------------------------------------------------------------------
// Serial line CSR unit checker
// Port-level checks on latency, reset and result encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "serial_line_csr_interface_unit_defines.svh"

module slci_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  read_data,
  input logic        tx_valid,
  input logic [6:0]  tx_char,
  input logic        irq_valid,
  input logic        irq_vector
);

  // A stalled result keeps its payload.
  `SLCI_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(read_data) && $stable(irq_valid) && $stable(tx_char),
    "stalled result changed")

  // Reset leaves no result pending.
  `SLCI_ASSERT_NEXT_ALWAYS(a_rst_empty, rst, !out_valid, "result valid after reset")

  // A taken request with a free result side passes the input register and then shows up as a valid result.
  `SLCI_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 !out_stall, out_valid,
    "request lost in pipeline")

  // A result without a transmitted character carries no character, and a transmitter vector only with an interrupt.
  `SLCI_ASSERT_NOW(a_tx_zero, out_valid && !tx_valid,
    tx_char == 7'd0 && (!irq_vector || irq_valid), "stray result bits")

endmodule

bind serial_line_csr_interface_unit slci_checker u_slci_checker (.*);

@@ tb/serial_line_csr_interface_unit_test.sv @@
// ----------------------------------------------------------------------------
// Serial line CSR interface unit testbench
// Drives bus reads, bus writes, ticks and received characters into the unit,
// predicts every response from a local copy of the register state, and
// checks each response field by field under random sender and receiver gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_line_csr_interface_unit_test;
  import slci_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  // Tracks the unit's register state and the responses still owed.
  class csr_line_scoreboard;
    logic [15:0] char_ticks;
    logic        rx_done;
    logic        rx_ie;
    logic [7:0]  rx_hold;
    logic        tx_ready;
    logic        tx_ie;
    logic [15:0] tx_count;
    rsp_t        predicted_responses[$];
    int unsigned mismatch_count;

    function new();
      char_ticks     = CHAR_TICKS_RESET;
      rx_done        = 1'b0;
      rx_ie          = 1'b0;
      rx_hold        = '0;
      tx_ready       = 1'b1;
      tx_ie          = 1'b0;
      tx_count       = '0;
      mismatch_count = 0;
    endfunction

    function void set_char_ticks(logic [15:0] value);
      char_ticks = value;
    endfunction

    function int unsigned pending_count();
      return predicted_responses.size();
    endfunction

    // Applies one accepted request to the state and queues its response.
    function void predict_request(req_t r);
      rsp_t      e;
      req_kind_t kind;
      sel_t      sel;
      e    = '0;
      kind = req_kind_t'(r.req_type);
      sel  = sel_t'(r.reg_offset[2:1]);
      case (kind)
        REQ_READ: begin
          case (sel)
            SEL_RX_STATUS: begin
              e.read_data[FLAG_BIT] = rx_done;
              e.read_data[IE_BIT]   = rx_ie;
            end
            SEL_RX_BUFFER: begin
              e.read_data = rx_hold;
              rx_done     = 1'b0;
            end
            SEL_TX_STATUS: begin
              e.read_data[FLAG_BIT] = tx_ready;
              e.read_data[IE_BIT]   = tx_ie;
            end
            default: ;
          endcase
        end
        REQ_WRITE: begin
          case (sel)
            SEL_RX_STATUS: begin
              rx_ie = r.write_data[IE_BIT];
              if (rx_ie && rx_done) begin
                e.irq_valid  = 1'b1;
                e.irq_vector = VEC_RX;
              end
            end
            SEL_TX_STATUS: begin
              tx_ie = r.write_data[IE_BIT];
              if (tx_ie && tx_ready) begin
                e.irq_valid  = 1'b1;
                e.irq_vector = VEC_TX;
              end
            end
            SEL_TX_BUFFER: begin
              e.tx_valid = 1'b1;
              e.tx_char  = r.write_data[6:0];
              tx_ready   = 1'b0;
              tx_count   = (char_ticks == 16'd0) ? 16'd1 : char_ticks;
            end
            default: ;
          endcase
        end
        REQ_TICK: begin
          // The countdown only runs while a character is on the line.
          if (!tx_ready) begin
            if (tx_count > 16'd1) begin
              tx_count = tx_count - 16'd1;
            end else begin
              tx_count = '0;
              tx_ready = 1'b1;
              if (tx_ie) begin
                e.irq_valid  = 1'b1;
                e.irq_vector = VEC_TX;
              end
            end
          end
        end
        default: begin
          // A character offered while one is still held is refused.
          if (!rx_done) begin
            rx_hold       = r.rx_char;
            rx_done       = 1'b1;
            e.rx_accepted = 1'b1;
            if (rx_ie) begin
              e.irq_valid  = 1'b1;
              e.irq_vector = VEC_RX;
            end
          end
        end
      endcase
      predicted_responses.push_back(e);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        mismatch_count++;
        if (mismatch_count <= 40)
          $display("%0t ns: %s expected 0x%0h got 0x%0h", $time, field, want, got);
      end
    endfunction

    // Compares one delivered response with the oldest prediction.
    function void check_response(rsp_t got);
      rsp_t want;
      if (predicted_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 40)
          $display("%0t ns: response expected none got 0x%0h", $time, got);
        return;
      end
      want = predicted_responses.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
      compare_field("tx_char", 8'(want.tx_char), 8'(got.tx_char));
      compare_field("irq_valid", 8'(want.irq_valid), 8'(got.irq_valid));
      compare_field("irq_vector", 8'(want.irq_vector), 8'(got.irq_vector));
      compare_field("rx_accepted", 8'(want.rx_accepted), 8'(got.rx_accepted));
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = '0;
  logic [2:0]  reg_offset = '0;
  logic [15:0] write_data = '0;
  logic [7:0]  rx_char = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_data;
  logic        tx_valid;
  logic [6:0]  tx_char;
  logic        irq_valid;
  logic        irq_vector;
  logic        rx_accepted;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned requests_taken = 0;
  int unsigned cycle_count = 0;

  csr_line_scoreboard line_sb = new();

  serial_line_csr_interface_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .reg_offset  (reg_offset),
    .write_data  (write_data),
    .rx_char     (rx_char),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .tx_valid    (tx_valid),
    .tx_char     (tx_char),
    .irq_valid   (irq_valid),
    .irq_vector  (irq_vector),
    .rx_accepted (rx_accepted),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, well above the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Response side: check what is taken, then pick the next stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      line_sb.check_response({read_data, tx_valid, tx_char, irq_valid, irq_vector,
                              rx_accepted});
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic req_t build_req(req_kind_t kind, sel_t sel, logic odd,
                                     logic [15:0] data, logic [7:0] ch);
    req_t r;
    r.req_type   = kind;
    r.reg_offset = {sel, odd};
    r.write_data = data;
    r.rx_char    = ch;
    return r;
  endfunction

  // Presents one request and holds it until the unit takes it.
  task automatic send_request(req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= r.req_type;
    reg_offset <= r.reg_offset;
    write_data <= r.write_data;
    rx_char    <= r.rx_char;
    do @(posedge clk); while (in_stall);
    line_sb.predict_request(r);
    requests_taken++;
  endtask

  // Stops sending until every predicted response has been delivered.
  task automatic wait_for_responses();
    in_valid <= 1'b0;
    while (line_sb.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_char_ticks(logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    line_sb.set_char_ticks(value);
  endtask

  task automatic send_random_item(req_kind_t kind, sel_t sel);
    send_request(build_req(kind, sel, 1'($urandom_range(0, 1)), 16'($urandom),
                           8'($urandom)));
  endtask

  // Mostly transmit and receive sequences with random content, plus noise.
  task automatic run_random(int unsigned count);
    int unsigned start;
    int unsigned pick;
    int unsigned span;
    int unsigned ticks;
    start = requests_taken;
    while (requests_taken - start < count) begin
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 59) == 0)
        wait_for_responses();
      if (pick <= 2) begin
        // Transmit: optional IE write, a character, some ticks, a status poll.
        if ($urandom_range(0, 1) == 1)
          send_random_item(REQ_WRITE, SEL_TX_STATUS);
        send_random_item(REQ_WRITE, SEL_TX_BUFFER);
        span  = (line_sb.char_ticks == 16'd0) ? 1 : line_sb.char_ticks;
        ticks = $urandom_range(0, (span < 12) ? span + 1 : 12);
        repeat (ticks) send_random_item(REQ_TICK, sel_t'($urandom_range(0, 3)));
        send_random_item(REQ_READ, SEL_TX_STATUS);
      end else if (pick <= 5) begin
        // Receive: one or two offers, a status poll, and mostly a buffer read.
        send_random_item(REQ_OFFER, sel_t'($urandom_range(0, 3)));
        if ($urandom_range(0, 2) == 0)
          send_random_item(REQ_OFFER, sel_t'($urandom_range(0, 3)));
        send_random_item(REQ_READ, SEL_RX_STATUS);
        if ($urandom_range(0, 3) != 0)
          send_random_item(REQ_READ, SEL_RX_BUFFER);
      end else if (pick <= 7) begin
        send_random_item(REQ_WRITE, SEL_RX_STATUS);
        send_random_item(REQ_OFFER, sel_t'($urandom_range(0, 3)));
      end else begin
        repeat ($urandom_range(1, 4))
          send_random_item(req_kind_t'($urandom_range(0, 3)),
                           sel_t'($urandom_range(0, 3)));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset character time.
    send_request(build_req(REQ_READ, SEL_RX_STATUS, 1'b0, 16'h0000, 8'h00));
    send_request(build_req(REQ_READ, SEL_TX_STATUS, 1'b1, 16'hFFFF, 8'hFF));
    send_request(build_req(REQ_READ, SEL_TX_BUFFER, 1'b0, 16'h0000, 8'h00));
    send_request(build_req(REQ_READ, SEL_RX_BUFFER, 1'b1, 16'h0000, 8'h00));
    send_request(build_req(REQ_WRITE, SEL_TX_STATUS, 1'b1, 16'hFFFF, 8'h00));
    send_request(build_req(REQ_WRITE, SEL_TX_BUFFER, 1'b1, 16'hFFFF, 8'h00));
    send_request(build_req(REQ_TICK, SEL_RX_STATUS, 1'b0, 16'h0000, 8'h00));
    send_request(build_req(REQ_READ, SEL_TX_STATUS, 1'b0, 16'h0000, 8'h00));
    // Writes to the receive buffer are ignored.
    send_request(build_req(REQ_WRITE, SEL_RX_BUFFER, 1'b1, 16'hFFFF, 8'h00));
    send_request(build_req(REQ_OFFER, SEL_RX_STATUS, 1'b0, 16'h0000, 8'hFF));
    // An offer while a character is held is refused.
    send_request(build_req(REQ_OFFER, SEL_RX_STATUS, 1'b0, 16'h0000, 8'h00));
    send_request(build_req(REQ_WRITE, SEL_RX_STATUS, 1'b1, 16'h0040, 8'h00));
    send_request(build_req(REQ_READ, SEL_RX_STATUS, 1'b0, 16'h0000, 8'h00));
    send_request(build_req(REQ_READ, SEL_RX_BUFFER, 1'b0, 16'h0000, 8'h00));
    send_request(build_req(REQ_OFFER, SEL_TX_BUFFER, 1'b1, 16'hFFFF, 8'h00));
    // Only the IE bit of a status write is stored.
    send_request(build_req(REQ_WRITE, SEL_RX_STATUS, 1'b0, 16'hFFBF, 8'h00));
    send_request(build_req(REQ_WRITE, SEL_TX_STATUS, 1'b0, 16'h0000, 8'h00));
    wait_for_responses();

    // A zero character time behaves as one tick.
    write_char_ticks(16'd0);
    send_request(build_req(REQ_WRITE, SEL_TX_STATUS, 1'b0, 16'h0040, 8'h00));
    // A buffer write while busy sends and restarts the countdown.
    send_request(build_req(REQ_WRITE, SEL_TX_BUFFER, 1'b0, 16'h0000, 8'h00));
    send_request(build_req(REQ_TICK, SEL_TX_BUFFER, 1'b1, 16'hFFFF, 8'hFF));
    // A tick while the transmitter is ready does nothing.
    send_request(build_req(REQ_TICK, SEL_RX_STATUS, 1'b0, 16'h0000, 8'h00));
    send_request(build_req(REQ_WRITE, SEL_TX_BUFFER, 1'b0, 16'h0055, 8'h00));
    send_request(build_req(REQ_WRITE, SEL_TX_BUFFER, 1'b1, 16'h002A, 8'h00));
    send_request(build_req(REQ_TICK, SEL_RX_STATUS, 1'b0, 16'h0000, 8'h00));
    send_request(build_req(REQ_READ, SEL_RX_BUFFER, 1'b1, 16'h0000, 8'h00));
    wait_for_responses();

    // Random phases at several character times and gap patterns.
    write_char_ticks(16'd1);
    idle_pct  = 0;
    stall_pct = 0;
    run_random(150);
    wait_for_responses();

    write_char_ticks(16'd3);
    idle_pct  = 78;
    stall_pct = 0;
    run_random(150);
    wait_for_responses();

    write_char_ticks(16'd7);
    idle_pct  = 0;
    stall_pct = 78;
    run_random(150);
    wait_for_responses();

    write_char_ticks(16'hFFFF);
    idle_pct  = 26;
    stall_pct = 26;
    run_random(120);
    wait_for_responses();

    write_char_ticks(16'd2);
    idle_pct  = 0;
    stall_pct = 0;
    run_random(70);
    wait_for_responses();
    idle_pct  = 26;
    stall_pct = 26;
    run_random(80);

    wait_for_responses();
    repeat (10) @(posedge clk);
    if (line_sb.mismatch_count == 0 && line_sb.pending_count() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/slci_pkg.sv
src/slci_in_stage.sv
src/slci_core.sv
src/slci_out_stage.sv
src/serial_line_csr_interface_unit.sv
src/slci_checker.sv
tb/serial_line_csr_interface_unit_test.sv
